/* rtl/lcbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_pkg: code block segmentation shared definitions
// word types, status codes, segmentation constants and small arithmetic helpers
// ----------------------------------------------------------------------------
package lcbs_pkg;

  // base graph code that selects graph one, everything else is graph two
  localparam logic [1:0] BG_ONE = 2'd1;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
  localparam logic [1:0] STATUS_ZC_RANGE = 2'd2;

  localparam logic [7:0] MAX_SEG_RESET = 8'd132;

  // maximum code block sizes and per segment crc
  localparam logic [13:0] KCB_BG1      = 14'd8448;
  localparam logic [13:0] KCB_BG2      = 14'd3840;
  localparam logic [4:0]  SEG_CRC_BITS = 5'd24;
  localparam logic [13:0] SEG_DIV_BG1  = KCB_BG1 - 14'(SEG_CRC_BITS);
  localparam logic [13:0] SEG_DIV_BG2  = KCB_BG2 - 14'(SEG_CRC_BITS);

  // segment count by reciprocal, exact for numerators below 2^22
  localparam int unsigned SEG_SHIFT = 36;
  localparam logic [24:0] SEG_RECIP_BG1 =
    25'(((64'd1 << SEG_SHIFT) + 64'(SEG_DIV_BG1) - 64'd1) / 64'(SEG_DIV_BG1));
  localparam logic [24:0] SEG_RECIP_BG2 =
    25'(((64'd1 << SEG_SHIFT) + 64'(SEG_DIV_BG2) - 64'd1) / 64'(SEG_DIV_BG2));

  // systematic column counts and graph two thresholds
  localparam logic [4:0]  KB_BG1   = 5'd22;
  localparam logic [4:0]  KB_TEN   = 5'd10;
  localparam logic [4:0]  KB_NINE  = 5'd9;
  localparam logic [4:0]  KB_EIGHT = 5'd8;
  localparam logic [4:0]  KB_SIX   = 5'd6;
  localparam logic [9:0]  KB_LIM_TEN   = 10'd640;
  localparam logic [9:0]  KB_LIM_NINE  = 10'd560;
  localparam logic [9:0]  KB_LIM_EIGHT = 10'd192;

  // code block length multipliers
  localparam logic [4:0]  KCOLS_BG1 = 5'd22;
  localparam logic [4:0]  KCOLS_BG2 = 5'd10;

  localparam logic [8:0]  ZC_MAX = 9'd384;

  // quotient bits of the per segment division
  localparam int unsigned QUOT_W = 14;

  // lifting size ceiling division by reciprocal, exact for numerators below 2^15
  localparam int unsigned ZC_SHIFT = 20;
  localparam logic [17:0] RECIP_KB22 =
    18'(((64'd1 << ZC_SHIFT) + 64'(KB_BG1) - 64'd1) / 64'(KB_BG1));
  localparam logic [17:0] RECIP_KB10 =
    18'(((64'd1 << ZC_SHIFT) + 64'(KB_TEN) - 64'd1) / 64'(KB_TEN));
  localparam logic [17:0] RECIP_KB9 =
    18'(((64'd1 << ZC_SHIFT) + 64'(KB_NINE) - 64'd1) / 64'(KB_NINE));
  localparam logic [17:0] RECIP_KB8 =
    18'(((64'd1 << ZC_SHIFT) + 64'(KB_EIGHT) - 64'd1) / 64'(KB_EIGHT));
  localparam logic [17:0] RECIP_KB6 =
    18'(((64'd1 << ZC_SHIFT) + 64'(KB_SIX) - 64'd1) / 64'(KB_SIX));

  typedef struct packed {
    logic [20:0] tb_bits;
    logic [1:0]  base_graph;
  } lcbs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  num_segments;
    logic [13:0] segment_bits;
    logic [4:0]  info_columns;
    logic [8:0]  lifting_size;
    logic [13:0] code_block_bits;
    logic [13:0] filler_bits;
  } lcbs_out_t;

  // classified word between front and back
  typedef struct packed {
    logic [20:0] tb_bits;
    logic [7:0]  num_seg;
    logic [4:0]  kb;
    logic        bg1;
    logic        seg_crc;
    logic        too_many;
  } lcbs_item_t;

  // divider stage contents
  typedef struct packed {
    logic [20:0]       rem;
    logic [QUOT_W-1:0] quot;
    logic [7:0]        num_seg;
    logic [4:0]        kb;
    logic              bg1;
    logic              seg_crc;
    logic              too_many;
  } lcbs_div_t;

  typedef struct packed {
    logic      valid;
    lcbs_div_t data;
  } lcbs_div_bus_t;

  // one restoring division step for quotient bit bit_idx
  function automatic lcbs_div_t div_step(input lcbs_div_t d, input logic [3:0] bit_idx);
    lcbs_div_t   r;
    logic [21:0] sub;
    r   = d;
    sub = 22'(d.num_seg) << bit_idx;
    if ({1'b0, d.rem} >= sub) begin
      r.rem           = d.rem - sub[20:0];
      r.quot[bit_idx] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [17:0] recip_kb(input logic [4:0] kb);
    logic [17:0] r;
    unique case (kb)
      KB_BG1:   r = RECIP_KB22;
      KB_TEN:   r = RECIP_KB10;
      KB_NINE:  r = RECIP_KB9;
      KB_EIGHT: r = RECIP_KB8;
      default:  r = RECIP_KB6;
    endcase
    return r;
  endfunction

  // smallest standard lifting size not below z, zero above the largest
  function automatic logic [8:0] pick_lifting(input logic [12:0] z);
    logic [8:0] zl;
    logic [8:0] r;
    zl = z[8:0];
    if (z <= 13'd2)              r = 9'd2;
    else if (z <= 13'd16)        r = zl;
    else if (z <= 13'd32)        r = (zl + 9'd1)  & ~9'd1;
    else if (z <= 13'd64)        r = (zl + 9'd3)  & ~9'd3;
    else if (z <= 13'd128)       r = (zl + 9'd7)  & ~9'd7;
    else if (z <= 13'd256)       r = (zl + 9'd15) & ~9'd15;
    else if (z <= 13'(ZC_MAX))   r = (zl + 9'd31) & ~9'd31;
    else                         r = '0;
    return r;
  endfunction

endpackage

/* rtl/lcbs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_front: input stage and classification
// takes words, finds the segment count and column count, flags overflow
// ----------------------------------------------------------------------------
module lcbs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  lcbs_pkg::lcbs_in_t   in_word_i,
  input  logic [7:0]           max_seg_i,
  output logic                 item_valid_o,
  output lcbs_pkg::lcbs_item_t item_o,
  input  logic                 item_full_i
);

  logic        a_v_q;
  logic [20:0] tb_q;
  logic        bg1_q;
  logic        small_q;
  logic [10:0] c_raw_q;

  logic        accept;
  logic        bg1_d;
  logic [13:0] div_d;
  logic [24:0] recip_d;
  logic [21:0] num_d;
  logic [46:0] prod_d;
  logic        small_d;
  logic [10:0] c_sel;
  logic [4:0]  kb_sel;

  assign accept = push_i && !full_o;
  assign full_o = a_v_q && item_full_i;

  // ceiling division of the block size by the segment payload
  assign bg1_d   = in_word_i.base_graph == lcbs_pkg::BG_ONE;
  assign div_d   = bg1_d ? lcbs_pkg::SEG_DIV_BG1 : lcbs_pkg::SEG_DIV_BG2;
  assign recip_d = bg1_d ? lcbs_pkg::SEG_RECIP_BG1 : lcbs_pkg::SEG_RECIP_BG2;
  assign num_d   = 22'(in_word_i.tb_bits) + 22'(div_d) - 22'd1;
  assign prod_d  = 47'(num_d) * 47'(recip_d);
  assign small_d = in_word_i.tb_bits <=
                   21'(bg1_d ? lcbs_pkg::KCB_BG1 : lcbs_pkg::KCB_BG2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (accept) begin
      a_v_q <= 1'b1;
    end else if (!item_full_i) begin
      a_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tb_q    <= in_word_i.tb_bits;
      bg1_q   <= bg1_d;
      small_q <= small_d;
      c_raw_q <= prod_d[46:36];
    end
  end

  // a block that fits whole is one segment with no segment crc
  assign c_sel = small_q ? 11'd1 : c_raw_q;

  always_comb begin
    if (bg1_q)                               kb_sel = lcbs_pkg::KB_BG1;
    else if (tb_q > 21'(lcbs_pkg::KB_LIM_TEN))   kb_sel = lcbs_pkg::KB_TEN;
    else if (tb_q > 21'(lcbs_pkg::KB_LIM_NINE))  kb_sel = lcbs_pkg::KB_NINE;
    else if (tb_q > 21'(lcbs_pkg::KB_LIM_EIGHT)) kb_sel = lcbs_pkg::KB_EIGHT;
    else                                     kb_sel = lcbs_pkg::KB_SIX;
  end

  assign item_valid_o     = a_v_q;
  assign item_o.tb_bits   = tb_q;
  assign item_o.num_seg   = c_sel[7:0];
  assign item_o.kb        = kb_sel;
  assign item_o.bg1       = bg1_q;
  assign item_o.seg_crc   = !small_q;
  assign item_o.too_many  = c_sel > 11'(max_seg_i);

endmodule

/* rtl/lcbs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_queue: classified word queue
// short first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
module lcbs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcbs_pkg::lcbs_item_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lcbs_pkg::lcbs_item_t rdata_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcbs_pkg::lcbs_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/lcbs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_div: pipelined segment size divider
// one quotient bit per stage, block size over segment count
// ----------------------------------------------------------------------------
module lcbs_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  lcbs_pkg::lcbs_div_bus_t in_i,
  output lcbs_pkg::lcbs_div_bus_t out_o
);

  localparam int unsigned Stages = lcbs_pkg::QUOT_W;

  lcbs_pkg::lcbs_div_t st_q [Stages];
  lcbs_pkg::lcbs_div_t st_d [Stages];
  logic [Stages-1:0]   v_q;

  // msb first, stage zero resolves the top quotient bit
  for (genvar s = 0; s < Stages; s++) begin : g_step
    if (s == 0) begin : g_first
      assign st_d[s] = lcbs_pkg::div_step(in_i.data, 4'(Stages - 1));
    end else begin : g_rest
      assign st_d[s] = lcbs_pkg::div_step(st_q[s-1], 4'(Stages - 1 - s));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign out_o.valid = v_q[Stages-1];
  assign out_o.data  = st_q[Stages-1];

endmodule

/* rtl/lcbs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbs_back: segment size, lifting size and result queue
// divides, picks the lifting size, forms the result word and buffers it
// ----------------------------------------------------------------------------
module lcbs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  lcbs_pkg::lcbs_item_t item_i,
  output logic                 item_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output lcbs_pkg::lcbs_out_t  out_word_o
);

  lcbs_pkg::lcbs_div_bus_t div_in, div_out;
  logic adv;

  // kprime stage
  logic        k_v_q;
  logic [13:0] k_kp_q;
  logic [14:0] k_n_q;
  logic [7:0]  k_seg_q;
  logic [4:0]  k_kb_q;
  logic        k_bg1_q;
  logic        k_tm_q;
  logic [13:0] kp_d;

  // lifting quotient stage
  logic        z_v_q;
  logic [12:0] z_q;
  logic [13:0] z_kp_q;
  logic [7:0]  z_seg_q;
  logic [4:0]  z_kb_q;
  logic        z_bg1_q;
  logic        z_tm_q;
  logic [32:0] zprod_d;

  // result forming
  logic [8:0]  zc;
  logic [13:0] kcb;
  lcbs_pkg::lcbs_out_t res;

  // two entry result queue
  lcbs_pkg::lcbs_out_t of_mem_q [2];
  logic       of_wr_q, of_rd_q;
  logic [1:0] of_cnt_q;
  logic       of_full, of_wr, of_rd;

  assign of_full = of_cnt_q == 2'd2;
  assign adv     = !(z_v_q && of_full);

  assign item_pop_o             = adv && item_valid_i;
  assign div_in.valid           = item_valid_i;
  assign div_in.data.rem        = item_i.tb_bits;
  assign div_in.data.quot       = '0;
  assign div_in.data.num_seg    = item_i.num_seg;
  assign div_in.data.kb         = item_i.kb;
  assign div_in.data.bg1        = item_i.bg1;
  assign div_in.data.seg_crc    = item_i.seg_crc;
  assign div_in.data.too_many   = item_i.too_many;

  lcbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .in_i   (div_in),
    .out_o  (div_out)
  );

  // (b + c*24) / c is b / c + 24 exactly
  assign kp_d = div_out.data.quot + (div_out.data.seg_crc ?
                14'(lcbs_pkg::SEG_CRC_BITS) : 14'd0);

  assign zprod_d = 33'(k_n_q) * 33'(lcbs_pkg::recip_kb(k_kb_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_v_q <= 1'b0;
      z_v_q <= 1'b0;
    end else if (adv) begin
      k_v_q <= div_out.valid;
      z_v_q <= k_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_kp_q  <= kp_d;
      k_n_q   <= 15'(kp_d) + 15'(div_out.data.kb) - 15'd1;
      k_seg_q <= div_out.data.num_seg;
      k_kb_q  <= div_out.data.kb;
      k_bg1_q <= div_out.data.bg1;
      k_tm_q  <= div_out.data.too_many;
      z_q     <= zprod_d[32:20];
      z_kp_q  <= k_kp_q;
      z_seg_q <= k_seg_q;
      z_kb_q  <= k_kb_q;
      z_bg1_q <= k_bg1_q;
      z_tm_q  <= k_tm_q;
    end
  end

  assign zc  = lcbs_pkg::pick_lifting(z_q);
  assign kcb = 14'(14'(zc) * 14'(z_bg1_q ? lcbs_pkg::KCOLS_BG1 : lcbs_pkg::KCOLS_BG2));

  always_comb begin
    res = '0;
    if (z_tm_q) begin
      res.status = lcbs_pkg::STATUS_TOO_MANY;
    end else if (zc == '0) begin
      res.status = lcbs_pkg::STATUS_ZC_RANGE;
    end else begin
      res.status          = lcbs_pkg::STATUS_OK;
      res.num_segments    = z_seg_q;
      res.segment_bits    = z_kp_q;
      res.info_columns    = z_kb_q;
      res.lifting_size    = zc;
      res.code_block_bits = kcb;
      res.filler_bits     = kcb - z_kp_q;
    end
  end

  assign of_wr      = z_v_q && !of_full;
  assign of_rd      = pop_i && !empty_o;
  assign empty_o    = of_cnt_q == 2'd0;
  assign out_word_o = of_mem_q[of_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= 1'b0;
      of_rd_q  <= 1'b0;
      of_cnt_q <= 2'd0;
    end else begin
      if (of_wr) begin
        of_wr_q <= !of_wr_q;
      end
      if (of_rd) begin
        of_rd_q <= !of_rd_q;
      end
      if (of_wr && !of_rd) begin
        of_cnt_q <= of_cnt_q + 2'd1;
      end else if (of_rd && !of_wr) begin
        of_cnt_q <= of_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_wr) begin
      of_mem_q[of_wr_q] <= res;
    end
  end

endmodule

/* rtl/ldpc_code_block_segmentation_params_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpc_code_block_segmentation_params_top: nr ldpc code block segmentation
// per transport block: segment count, segment size, columns, lifting size,
// code block length and filler count
//
//   channel   direction   handshake            word
//   input     in          push / full          in_word_i   (tb_bits, base_graph)
//   result    out         empty / pop          out_word_o  (status ... filler_bits)
//   config    in          cfg_we_i             cfg_wdata_i (max_segments)
//
// one word per cycle sustained unless the front or the back stalls; a result
// passes the front register, the queue, the 14 stage segment size divider,
// then the kprime, lifting multiply and result queue registers
// reset clears all valid state and loads max_segments with 132
// the front stalls only when its output register and the 4 word queue are
// full; the back pipeline stalls as a whole when its 2 word result queue is full
// ----------------------------------------------------------------------------
module ldpc_code_block_segmentation_params_top #(
  parameter int unsigned MidDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input word side
  input  logic                push,
  output logic                full,
  input  lcbs_pkg::lcbs_in_t  in_word_i,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output lcbs_pkg::lcbs_out_t out_word_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  // segment count limit
  logic [7:0] max_seg_q;

  // front to queue
  logic                 fr_valid;
  lcbs_pkg::lcbs_item_t fr_item;
  logic                 mq_full;

  // queue to back
  lcbs_pkg::lcbs_item_t mq_item;
  logic                 mq_empty;
  logic                 bk_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q <= lcbs_pkg::MAX_SEG_RESET;
    end else if (cfg_we_i) begin
      max_seg_q <= cfg_wdata_i;
    end
  end

  // front: registers the word, segment count by reciprocal multiply,
  // column count and the too many segments check
  lcbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_word_i    (in_word_i),
    .max_seg_i    (max_seg_q),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_full_i  (mq_full)
  );

  // decoupling queue, lets front and back stall on their own
  lcbs_queue #(
    .Depth (MidDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .wdata_i (fr_item),
    .full_o  (mq_full),
    .pop_i   (bk_pop),
    .rdata_o (mq_item),
    .empty_o (mq_empty)
  );

  // back: divider pipeline, lifting size pick, result word and result queue
  lcbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mq_empty),
    .item_i       (mq_item),
    .item_pop_o   (bk_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_word_o   (out_word_o)
  );

`ifndef SYNTHESIS
  // an error result carries nothing but its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status != lcbs_pkg::STATUS_OK) |->
      (out_word_o.num_segments == '0 && out_word_o.segment_bits == '0 &&
       out_word_o.info_columns == '0 && out_word_o.lifting_size == '0 &&
       out_word_o.code_block_bits == '0 && out_word_o.filler_bits == '0))
    else $error("error result with nonzero fields");

  // code block length splits into segment bits and filler
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status == lcbs_pkg::STATUS_OK) |->
      (out_word_o.code_block_bits ==
       14'(out_word_o.segment_bits + out_word_o.filler_bits)))
    else $error("code block length mismatch");

  // a good result has at least one segment and a real lifting size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status == lcbs_pkg::STATUS_OK) |->
      (out_word_o.num_segments != '0 && out_word_o.lifting_size != '0 &&
       out_word_o.code_block_bits >= out_word_o.segment_bits))
    else $error("good result with empty segment or lifting size");
`endif

endmodule
